@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the channel load rate controller.
// Depends on nothing; expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/clrsm_pkg.sv @@
// Package for the channel load rate controller: types, codes, constants and
// the level and interval functions. Depends on nothing.
package clrsm_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int COUNT_WIDTH  = 24;
  localparam int RATIO_BITS   = 10;
  localparam int RATIO_W      = RATIO_BITS + 1;

  typedef logic [RATIO_W-1:0] ratio_t;
  typedef logic [2:0]         level_t;

  localparam ratio_t RATIO_ONE = ratio_t'(1) << RATIO_BITS;
  localparam level_t MAX_LEVEL = 3'd4;

  // Command codes of an input item.
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_MEASURE = 2'd1;
  localparam logic [1:0] CMD_EVAL    = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_LEVEL1 = 3'd0;
  localparam logic [2:0] REG_LEVEL2 = 3'd1;
  localparam logic [2:0] REG_LEVEL3 = 3'd2;
  localparam logic [2:0] REG_LEVEL4 = 3'd3;
  localparam logic [2:0] REG_UP_LEN = 3'd4;
  localparam logic [2:0] REG_DN_LEN = 3'd5;

  // Reset values of the configuration registers.
  localparam ratio_t     LEVEL1_RESET = 11'd154;
  localparam ratio_t     LEVEL2_RESET = 11'd256;
  localparam ratio_t     LEVEL3_RESET = 11'd358;
  localparam ratio_t     LEVEL4_RESET = 11'd410;
  localparam logic [3:0] UP_LEN_RESET = 4'd1;
  localparam logic [3:0] DN_LEN_RESET = 4'd5;

  typedef struct packed {
    logic [1:0] command;
    logic       channel_busy;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  dcc_state;
    logic [9:0]  packet_interval_ms;
    logic [10:0] last_ratio;
    logic        state_changed;
  } out_item_t;

  // Running window extremes that travel down the cell chain.
  typedef struct packed {
    logic   valid;
    ratio_t min;
    ratio_t max;
  } scan_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic shift;
    logic up_en;
    logic down_en;
  } cell_ctl_t;

  function automatic level_t load_level(input ratio_t r, input ratio_t t1, input ratio_t t2,
                                        input ratio_t t3, input ratio_t t4);
    level_t lv;
    if (r >= t4) lv = 3'd4;
    else if (r >= t3) lv = 3'd3;
    else if (r >= t2) lv = 3'd2;
    else if (r >= t1) lv = 3'd1;
    else lv = 3'd0;
    return lv;
  endfunction

  function automatic logic [9:0] interval_ms(input level_t lv);
    logic [9:0] ms;
    case (lv)
      3'd0:    ms = 10'd40;
      3'd1:    ms = 10'd100;
      3'd2:    ms = 10'd300;
      3'd3:    ms = 10'd500;
      default: ms = 10'd1000;
    endcase
    return ms;
  endfunction

endpackage

@@ rtl/clrsm_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on clrsm_pkg for the payload types.
interface clrsm_in_if;
  logic                valid;
  logic                ready;
  clrsm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clrsm_out_if;
  logic                 valid;
  logic                 ready;
  clrsm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/clrsm_div.sv @@
// Serial restoring divider giving busy * 2^RATIO_BITS / total, one bit a cycle.
// Depends on clrsm_pkg.
module clrsm_div #(
  parameter int COUNT_WIDTH = clrsm_pkg::COUNT_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [COUNT_WIDTH-1:0]   dividend,
  input  logic [COUNT_WIDTH-1:0]   divisor,
  output logic                     done,
  output clrsm_pkg::ratio_t        quotient
);

  localparam int STEPS = clrsm_pkg::RATIO_BITS + 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [COUNT_WIDTH:0]   rem;
  logic [COUNT_WIDTH-1:0] den;
  clrsm_pkg::ratio_t      quo;
  logic [CNT_W-1:0]       cnt;
  logic                   active;
  logic                   fits;
  logic [COUNT_WIDTH:0]   rem_sub;
  logic [COUNT_WIDTH:0]   rem_next;

  // Busy never exceeds total, so the remainder stays below the divisor after
  // each subtract and the doubled value fits one extra bit.
  assign fits     = rem >= {1'b0, den};
  assign rem_sub  = fits ? rem - {1'b0, den} : rem;
  assign rem_next = {rem_sub[COUNT_WIDTH-1:0], 1'b0};
  assign quotient = (den == '0) ? '0 : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(STEPS);
      end else if (active) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, dividend};
      den <= divisor;
      quo <= '0;
    end else if (active) begin
      rem <= rem_next;
      quo <= {quo[clrsm_pkg::RATIO_W-2:0], fits};
    end
  end

endmodule

@@ rtl/clrsm_cell.sv @@
// One cell of the ratio chain: holds one measured ratio and folds it into the
// window minimum and maximum passing through. Depends on clrsm_pkg.
module clrsm_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  clrsm_pkg::cell_ctl_t  ctl,
  input  clrsm_pkg::ratio_t     ratio_in,
  output clrsm_pkg::ratio_t     ratio,
  input  clrsm_pkg::scan_t      scan_in,
  output clrsm_pkg::scan_t      scan_out
);

  logic take_min;
  logic take_max;

  assign take_min = ctl.up_en && (ratio < scan_in.min);
  assign take_max = ctl.down_en && (ratio > scan_in.max);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      ratio <= ratio_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out.valid <= scan_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    scan_out.min <= take_min ? ratio : scan_in.min;
    scan_out.max <= take_max ? ratio : scan_in.max;
  end

endmodule

@@ rtl/channel_load_rate_state_machine_core.sv @@
// Top level of the channel load rate controller with its control sequencer.
// Depends on clrsm_pkg, clrsm_if, clrsm_cell, clrsm_div and assert_macros.svh.

// The block keeps a five-state congestion level from the channel busy ratio.
// Each input item carries a command: a sense tick adds to the busy and total
// counts, an end of measure interval divides busy by total into a Q1.10 ratio
// and pushes it into a chain of WINDOW_DEPTH cells, and an evaluate compares
// the minimum over the newest up-window ratios and the maximum over the newest
// down-window ratios with four thresholds to move the level up or down. Every
// item produces exactly one result transfer with the level, its beacon interval,
// the latest ratio and a flag telling whether this item moved the level. Items
// are processed one at a time: a measure waits for the serial divider, which
// retires one quotient bit per cycle, and an evaluate waits for the running
// minimum and maximum, which step through one cell per cycle. A finished
// result sits in an output register, so the next item is taken while the
// result waits to be picked up; a second result only waits for the register
// to empty. The ratio cells hold no reset value: a cell is consulted only
// after a measure wrote it. Configuration writes are taken at any time but
// must only be issued while the block is idle.
`include "assert_macros.svh"

module channel_load_rate_state_machine_core #(
  parameter int WINDOW_DEPTH = clrsm_pkg::WINDOW_DEPTH,
  parameter int COUNT_WIDTH  = clrsm_pkg::COUNT_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  clrsm_in_if.sink                    item,
  clrsm_out_if.source                 result,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [clrsm_pkg::RATIO_W-1:0] cfg_data
);

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SCAN = 4'b0100,
    S_POST = 4'b1000
  } seq_state_t;

  seq_state_t state;

  // Configuration registers.
  clrsm_pkg::ratio_t thr1;
  clrsm_pkg::ratio_t thr2;
  clrsm_pkg::ratio_t thr3;
  clrsm_pkg::ratio_t thr4;
  logic [3:0]        up_len;
  logic [3:0]        down_len;

  // Measurement and level state.
  logic [COUNT_WIDTH-1:0] busy_cnt;
  logic [COUNT_WIDTH-1:0] total_cnt;
  logic [FILL_W-1:0]      fill;
  clrsm_pkg::level_t      level;
  clrsm_pkg::level_t      level_next;
  clrsm_pkg::level_t      up_lv;
  clrsm_pkg::level_t      down_lv;
  clrsm_pkg::ratio_t      latest_ratio;
  logic                   changed;

  logic              accept;
  logic              post_load;
  logic              div_start;
  logic              div_done;
  clrsm_pkg::ratio_t div_quotient;
  logic              ring_shift;
  logic              scan_start;

  clrsm_pkg::cell_ctl_t cell_ctl  [WINDOW_DEPTH];
  clrsm_pkg::ratio_t    ratio_link [WINDOW_DEPTH+1];
  clrsm_pkg::scan_t     scan_link  [WINDOW_DEPTH+1];
  clrsm_pkg::scan_t     scan_last;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;

  // A measure starts the divider with the counts as they stand at the transfer.
  assign div_start  = accept && (item.data.command == clrsm_pkg::CMD_MEASURE);
  // An evaluate with at least one stored ratio sends a scan token down the cells.
  assign scan_start = accept && (item.data.command == clrsm_pkg::CMD_EVAL) && (fill != '0);
  // The new ratio enters the first cell and every cell hands its ratio onward.
  assign ring_shift = (state == S_DIV) && div_done;
  // The result register takes a new result when it is empty or being emptied.
  assign post_load  = (state == S_POST) && (!result.valid || result.ready);

  clrsm_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (busy_cnt),
    .divisor  (total_cnt),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // The scan starts with the neutral extremes; the first cell is always in
  // both windows, so the neutral values never survive to the end.
  assign scan_link[0].valid = scan_start;
  assign scan_link[0].min   = clrsm_pkg::RATIO_ONE;
  assign scan_link[0].max   = '0;
  assign ratio_link[0]      = div_quotient;
  assign scan_last          = scan_link[WINDOW_DEPTH];

  // Cell k holds the ratio measured k intervals ago. It joins a window when it
  // has been written and lies within the window length (a length of zero
  // counts as one).
  always_comb begin
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      cell_ctl[k].shift   = ring_shift;
      cell_ctl[k].up_en   = (k < int'(fill)) && ((k == 0) || (k < int'(up_len)));
      cell_ctl[k].down_en = (k < int'(fill)) && ((k == 0) || (k < int'(down_len)));
    end
  end

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    clrsm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl[g]),
      .ratio_in (ratio_link[g]),
      .ratio    (ratio_link[g+1]),
      .scan_in  (scan_link[g]),
      .scan_out (scan_link[g+1])
    );
  end

  // Rising takes priority over falling: the level rises to the level of the
  // window minimum, otherwise falls to the level of the window maximum.
  always_comb begin
    up_lv   = clrsm_pkg::load_level(scan_last.min, thr1, thr2, thr3, thr4);
    down_lv = clrsm_pkg::load_level(scan_last.max, thr1, thr2, thr3, thr4);
    if (up_lv > level) begin
      level_next = up_lv;
    end else if (down_lv < level) begin
      level_next = down_lv;
    end else begin
      level_next = level;
    end
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr1     <= clrsm_pkg::LEVEL1_RESET;
      thr2     <= clrsm_pkg::LEVEL2_RESET;
      thr3     <= clrsm_pkg::LEVEL3_RESET;
      thr4     <= clrsm_pkg::LEVEL4_RESET;
      up_len   <= clrsm_pkg::UP_LEN_RESET;
      down_len <= clrsm_pkg::DN_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        clrsm_pkg::REG_LEVEL1: thr1     <= cfg_data;
        clrsm_pkg::REG_LEVEL2: thr2     <= cfg_data;
        clrsm_pkg::REG_LEVEL3: thr3     <= cfg_data;
        clrsm_pkg::REG_LEVEL4: thr4     <= cfg_data;
        clrsm_pkg::REG_UP_LEN: up_len   <= cfg_data[3:0];
        clrsm_pkg::REG_DN_LEN: down_len <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer and measurement state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy_cnt     <= '0;
      total_cnt    <= '0;
      fill         <= '0;
      level        <= '0;
      latest_ratio <= '0;
      changed      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            changed <= 1'b0;
            case (item.data.command)
              clrsm_pkg::CMD_TICK: begin
                // Both counts stop at full scale; busy never passes total.
                if (total_cnt != COUNT_MAX) begin
                  total_cnt <= total_cnt + COUNT_WIDTH'(1);
                  if (item.data.channel_busy && (busy_cnt != COUNT_MAX)) begin
                    busy_cnt <= busy_cnt + COUNT_WIDTH'(1);
                  end
                end
                state <= S_POST;
              end
              clrsm_pkg::CMD_MEASURE: state <= S_DIV;
              clrsm_pkg::CMD_EVAL: begin
                // With no ratio stored yet the level is kept.
                state <= (fill != '0) ? S_SCAN : S_POST;
              end
              default: state <= S_POST;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            latest_ratio <= div_quotient;
            busy_cnt     <= '0;
            total_cnt    <= '0;
            if (fill != FILL_W'(WINDOW_DEPTH)) begin
              fill <= fill + FILL_W'(1);
            end
            state <= S_POST;
          end
        end
        S_SCAN: begin
          if (scan_last.valid) begin
            level   <= level_next;
            changed <= (level_next != level);
            state   <= S_POST;
          end
        end
        S_POST: begin
          if (post_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (post_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_load) begin
      result.data.dcc_state          <= level;
      result.data.packet_interval_ms <= clrsm_pkg::interval_ms(level);
      result.data.last_ratio         <= latest_ratio;
      result.data.state_changed      <= changed;
    end
  end

  `ASSERT_IMPLIES(a_level_range, 1'b1, level <= clrsm_pkg::MAX_LEVEL, "level above four")
  `ASSERT_IMPLIES(a_scan_owner, scan_last.valid, state == S_SCAN, "scan ended outside scan state")
  `ASSERT_IMPLIES(a_div_owner, div_done, state == S_DIV, "divider finished outside divide state")
  `ASSERT_NEXT(a_changed_flag, (state == S_SCAN) && scan_last.valid,
    changed == (level != $past(level)), "change flag disagrees with level")

endmodule
